FILE: rtl/core/bbw_pkg.sv
// ----------------------------------------------------------------------------
// bbw_pkg
// Shared types and constants of the brew-by-weight shot controller: field
// widths, register indexes, phase codes and the result item layout.
// ----------------------------------------------------------------------------
package bbw_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int TIME_W     = 16;
   localparam int TARGET_W   = 14;
   localparam int DEBOUNCE_W = 10;
   localparam int PHASE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TARGET_W-1:0]   TARGET_MAX   = 14'd9999;
   localparam logic [TARGET_W-1:0]   TARGET_RESET = 14'd300;
   localparam logic [DEBOUNCE_W-1:0] SINCE_MAX    = 10'd1023;
   localparam logic [TIME_W-1:0]     TIME_MAX     = 16'hFFFF;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd300;
   localparam logic [TIME_W-1:0]     CANCEL_RESET   = 16'd8000;
   localparam logic [TIME_W-1:0]     MIN_STOP_RESET = 16'd10000;
   localparam logic [TIME_W-1:0]     MAX_SHOT_RESET = 16'd50000;
   localparam logic [TIME_W-1:0]     DRIP_RESET     = 16'd3000;

   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_BREW = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_POST = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE     = 3'd0,
      CSR_CANCEL_LIMIT = 3'd1,
      CSR_MIN_STOP     = 3'd2,
      CSR_MAX_SHOT     = 3'd3,
      CSR_DRIP         = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_BREW = 3'b010,
      PH_POST = 3'b100
   } phase_type;

   typedef struct packed {
      logic [PHASE_W-1:0]         phase;
      logic                       pump_on;
      logic [TARGET_W-1:0]        goal_weight;
      logic signed [WEIGHT_W-1:0] shot_weight;
      logic [TIME_W-1:0]          shot_time_ms;
      logic signed [WEIGHT_W-1:0] last_weight;
      logic [TIME_W-1:0]          last_time_ms;
      logic                       shot_done;
   } rsp_type;

endpackage

FILE: rtl/core/bbw_req_if.sv
// ----------------------------------------------------------------------------
// bbw_req_if
// Input channel: one millisecond tick with button, encoder and scale data.
// ----------------------------------------------------------------------------
interface bbw_req_if;
   import bbw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       button_press;
   logic                       enc_a;
   logic                       enc_b;
   logic signed [WEIGHT_W-1:0] scale_weight;

   modport source (output valid, output button_press, output enc_a, output enc_b,
                   output scale_weight, input ready);
   modport sink (input valid, input button_press, input enc_a, input enc_b,
                 input scale_weight, output ready);
endinterface

FILE: rtl/core/bbw_rsp_if.sv
// ----------------------------------------------------------------------------
// bbw_rsp_if
// Result channel: controller status for one tick.
// ----------------------------------------------------------------------------
interface bbw_rsp_if;
   import bbw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [PHASE_W-1:0]         phase;
   logic                       pump_on;
   logic [TARGET_W-1:0]        goal_weight;
   logic signed [WEIGHT_W-1:0] shot_weight;
   logic [TIME_W-1:0]          shot_time_ms;
   logic signed [WEIGHT_W-1:0] last_weight;
   logic [TIME_W-1:0]          last_time_ms;
   logic                       shot_done;

   modport source (output valid, output phase, output pump_on, output goal_weight,
                   output shot_weight, output shot_time_ms, output last_weight,
                   output last_time_ms, output shot_done, input ready);
   modport sink (input valid, input phase, input pump_on, input goal_weight,
                 input shot_weight, input shot_time_ms, input last_weight,
                 input last_time_ms, input shot_done, output ready);
endinterface

FILE: rtl/core/bbw_csr_if.sv
// ----------------------------------------------------------------------------
// bbw_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbw_csr_if;
   import bbw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/brew_by_weight_shot_controller.sv
// ----------------------------------------------------------------------------
// brew_by_weight_shot_controller
// Shot controller stepped once per millisecond tick item.
// ----------------------------------------------------------------------------
// Usage:
//  req_item carries one tick: button press event, encoder levels and the
//  summed scale weight. rsp_item returns one status item per tick: phase,
//  pump drive, target, tared weight, brew time, latched last shot and the
//  shot_done pulse. csr_write sets the five timing registers by index; it
//  is always ready and a write to an unknown index is dropped.
//  The status of a tick is registered and appears on rsp_item in the
//  cycle after its item is accepted. Throughput is one item per cycle;
//  the controller state and the result register both update on the
//  accepting edge, so the next tick can enter at once.
//  When the receiver stalls, the result register holds and req_item.ready
//  drops until the held item is taken; nothing is lost or repeated.
//  Reset (synchronous, active high) restores idle phase, clears timers,
//  tare and last shot, sets the target to 30.0 g and the registers to
//  their defaults, and empties the result register.
// ----------------------------------------------------------------------------
module brew_by_weight_shot_controller (
   input logic       clock,
   input logic       reset,
   bbw_req_if.sink   req_item,
   bbw_rsp_if.source rsp_item,
   bbw_csr_if.sink   csr_write
);
   import bbw_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [TIME_W-1:0]     cancel_ff, min_stop_ff, max_shot_ff, drip_ff;

   phase_type                  phase_ff, phase_in;
   logic [DEBOUNCE_W-1:0]      since_ff, since_in;
   logic [TIME_W-1:0]          brew_ff, brew_in;
   logic [TIME_W-1:0]          drip_timer_ff, drip_timer_in;
   logic signed [WEIGHT_W-1:0] tare_ff, tare_in;
   logic [TARGET_W-1:0]        target_ff, target_in;
   logic                       enc_prev_ff, enc_prev_in;
   logic                       latched_ff, latched_in;
   logic signed [WEIGHT_W-1:0] last_weight_ff, last_weight_in;
   logic [TIME_W-1:0]          last_time_ff, last_time_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                       accept;
   logic [DEBOUNCE_W-1:0]      since_inc;
   logic                       press;
   logic [TIME_W-1:0]          brew_inc, drip_inc;
   logic signed [WEIGHT_W:0]   diff;
   logic signed [WEIGHT_W-1:0] tared_cur, tared_out;
   logic                       over_target;
   logic                       done;

   assign req_item.ready  = !rsp_valid_ff || rsp_item.ready;
   assign accept          = req_item.valid && req_item.ready;
   assign csr_write.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         cancel_ff   <= CANCEL_RESET;
         min_stop_ff <= MIN_STOP_RESET;
         max_shot_ff <= MAX_SHOT_RESET;
         drip_ff     <= DRIP_RESET;
      end else if (csr_write.valid) begin
         case (csr_index_type'(csr_write.index))
            CSR_DEBOUNCE:     debounce_ff <= csr_write.data[DEBOUNCE_W-1:0];
            CSR_CANCEL_LIMIT: cancel_ff   <= csr_write.data[TIME_W-1:0];
            CSR_MIN_STOP:     min_stop_ff <= csr_write.data[TIME_W-1:0];
            CSR_MAX_SHOT:     max_shot_ff <= csr_write.data[TIME_W-1:0];
            CSR_DRIP:         drip_ff     <= csr_write.data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      since_inc = (since_ff != SINCE_MAX) ? since_ff + 1'b1 : since_ff;
      press     = req_item.button_press &&
                  ((since_inc > debounce_ff) || (since_inc == SINCE_MAX));
      since_in  = press ? '0 : since_inc;
      brew_inc  = (brew_ff != TIME_MAX) ? brew_ff + 1'b1 : brew_ff;
      drip_inc  = (drip_timer_ff != TIME_MAX) ? drip_timer_ff + 1'b1 : drip_timer_ff;

      diff = {req_item.scale_weight[WEIGHT_W-1], req_item.scale_weight} -
             {tare_ff[WEIGHT_W-1], tare_ff};
      if (diff[WEIGHT_W] != diff[WEIGHT_W-1]) begin
         tared_cur = diff[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                    : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         tared_cur = diff[WEIGHT_W-1:0];
      end
      over_target = tared_cur > $signed({{(WEIGHT_W-TARGET_W){1'b0}}, target_ff});

      phase_in       = phase_ff;
      brew_in        = brew_ff;
      drip_timer_in  = drip_timer_ff;
      tare_in        = tare_ff;
      target_in      = target_ff;
      enc_prev_in    = enc_prev_ff;
      latched_in     = latched_ff;
      last_weight_in = last_weight_ff;
      last_time_in   = last_time_ff;
      done           = 1'b0;
      tared_out      = tared_cur;

      case (phase_ff)
         PH_BREW: begin
            brew_in = brew_inc;
            if (press) begin
               phase_in = (brew_inc < cancel_ff) ? PH_IDLE : PH_POST;
            end else if ((over_target && brew_inc > min_stop_ff) ||
                         brew_inc >= max_shot_ff) begin
               phase_in = PH_POST;
            end
            if (phase_in == PH_POST) begin
               drip_timer_in = '0;
            end
            if (phase_in != PH_BREW) begin
               latched_in = 1'b0;
            end
         end
         PH_POST: begin
            drip_timer_in = drip_inc;
            if (drip_inc >= drip_ff && !latched_ff) begin
               last_weight_in = tared_cur;
               last_time_in   = brew_ff;
               latched_in     = 1'b1;
               done           = 1'b1;
            end
            if (press) begin
               phase_in   = PH_IDLE;
               latched_in = 1'b0;
            end
         end
         default: begin
            phase_in   = PH_IDLE;
            latched_in = 1'b0;
            if (!enc_prev_ff && req_item.enc_a) begin
               if (req_item.enc_b) begin
                  if (target_ff != '0) begin
                     target_in = target_ff - 1'b1;
                  end
               end else if (target_ff < TARGET_MAX) begin
                  target_in = target_ff + 1'b1;
               end
            end
            enc_prev_in = req_item.enc_a;
            if (press) begin
               tare_in   = req_item.scale_weight;
               brew_in   = '0;
               phase_in  = PH_BREW;
               tared_out = '0;
            end
         end
      endcase

      case (phase_in)
         PH_BREW: rsp_in.phase = PHASE_CODE_BREW;
         PH_POST: rsp_in.phase = PHASE_CODE_POST;
         default: rsp_in.phase = PHASE_CODE_IDLE;
      endcase
      rsp_in.pump_on      = (phase_in == PH_BREW);
      rsp_in.goal_weight  = target_in;
      rsp_in.shot_weight  = tared_out;
      rsp_in.shot_time_ms = brew_in;
      rsp_in.last_weight  = last_weight_in;
      rsp_in.last_time_ms = last_time_in;
      rsp_in.shot_done    = done;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_item.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         since_ff       <= '0;
         brew_ff        <= '0;
         drip_timer_ff  <= '0;
         tare_ff        <= '0;
         target_ff      <= TARGET_RESET;
         enc_prev_ff    <= 1'b1;
         latched_ff     <= 1'b0;
         last_weight_ff <= '0;
         last_time_ff   <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         since_ff       <= since_in;
         brew_ff        <= brew_in;
         drip_timer_ff  <= drip_timer_in;
         tare_ff        <= tare_in;
         target_ff      <= target_in;
         enc_prev_ff    <= enc_prev_in;
         latched_ff     <= latched_in;
         last_weight_ff <= last_weight_in;
         last_time_ff   <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item.valid        = rsp_valid_ff;
   assign rsp_item.phase        = rsp_ff.phase;
   assign rsp_item.pump_on      = rsp_ff.pump_on;
   assign rsp_item.goal_weight  = rsp_ff.goal_weight;
   assign rsp_item.shot_weight  = rsp_ff.shot_weight;
   assign rsp_item.shot_time_ms = rsp_ff.shot_time_ms;
   assign rsp_item.last_weight  = rsp_ff.last_weight;
   assign rsp_item.last_time_ms = rsp_ff.last_time_ms;
   assign rsp_item.shot_done    = rsp_ff.shot_done;

   a_done_not_brewing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.shot_done |-> rsp_ff.phase != PHASE_CODE_BREW)
      else $error("shot_done while brewing");

   a_pump_brew: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.pump_on == (rsp_ff.phase == PHASE_CODE_BREW))
      else $error("pump drive does not match phase");

   a_shot_start: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff != PH_BREW && phase_ff != PH_POST && phase_in == PH_BREW
      |=> rsp_item.shot_time_ms == '0 && rsp_item.shot_weight == '0
          && phase_ff == PH_BREW)
      else $error("shot start did not tare and clear timer");

   a_press_clears: assert property (@(posedge clock) disable iff (reset)
      accept && press |=> since_ff == '0)
      else $error("accepted press did not restart debounce count");

   a_target_bound: assert property (@(posedge clock) disable iff (reset)
      accept |=> target_ff <= TARGET_MAX && $past(since_in) == since_ff)
      else $error("target or debounce state out of step");

endmodule

FILE: tb/shot_status_checker.sv
// ----------------------------------------------------------------------------
// shot_status_checker
// Watches the tick, status and register channels of the shot controller.
// Keeps its own copy of the controller state and timing registers, works
// out the status of every accepted tick and compares each accepted status
// item, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module shot_status_checker (
   input  logic clock,
   input  logic reset,
   bbw_req_if   req_mon,
   bbw_rsp_if   rsp_mon,
   bbw_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import bbw_pkg::*;

   logic [DEBOUNCE_W-1:0]      debounce_cfg;
   logic [TIME_W-1:0]          cancel_cfg;
   logic [TIME_W-1:0]          min_stop_cfg;
   logic [TIME_W-1:0]          max_shot_cfg;
   logic [TIME_W-1:0]          drip_cfg;

   logic [PHASE_W-1:0]         phase_now;
   logic [DEBOUNCE_W-1:0]      since_press;
   logic [TIME_W-1:0]          brew_ms;
   logic [TIME_W-1:0]          drip_ticks;
   logic signed [WEIGHT_W-1:0] tare_wt;
   logic [TARGET_W-1:0]        target_wt;
   logic                       enc_a_was;
   logic                       latched;
   logic signed [WEIGHT_W-1:0] last_wt;
   logic [TIME_W-1:0]          last_ms;

   rsp_type status_due[$];
   rsp_type want;

   function automatic logic signed [WEIGHT_W-1:0] net_weight(
      input logic signed [WEIGHT_W-1:0] w);
      int diff;
      diff = int'(w) - int'(tare_wt);
      if (diff > 32767) begin
         diff = 32767;
      end else if (diff < -32768) begin
         diff = -32768;
      end
      return diff[WEIGHT_W-1:0];
   endfunction

   function automatic rsp_type advance_tick(input logic press_in, input logic a,
                                            input logic b,
                                            input logic signed [WEIGHT_W-1:0] w);
      rsp_type st;
      logic    press;
      logic    done;
      press = 1'b0;
      done  = 1'b0;
      if (since_press != SINCE_MAX) since_press = since_press + 1'b1;
      if (press_in && (since_press > debounce_cfg || since_press == SINCE_MAX)) begin
         press       = 1'b1;
         since_press = '0;
      end
      case (phase_now)
         PHASE_CODE_BREW: begin
            if (brew_ms != TIME_MAX) brew_ms = brew_ms + 1'b1;
            if (press) begin
               phase_now = (brew_ms < cancel_cfg) ? PHASE_CODE_IDLE : PHASE_CODE_POST;
            end else if ((int'(net_weight(w)) > int'(target_wt) && brew_ms > min_stop_cfg)
                         || brew_ms >= max_shot_cfg) begin
               phase_now = PHASE_CODE_POST;
            end
            if (phase_now == PHASE_CODE_POST) begin
               drip_ticks = '0;
               latched    = 1'b0;
            end
            if (phase_now == PHASE_CODE_IDLE) latched = 1'b0;
         end
         PHASE_CODE_POST: begin
            if (drip_ticks != TIME_MAX) drip_ticks = drip_ticks + 1'b1;
            if (drip_ticks >= drip_cfg && !latched) begin
               last_wt = net_weight(w);
               last_ms = brew_ms;
               latched = 1'b1;
               done    = 1'b1;
            end
            if (press) begin
               phase_now = PHASE_CODE_IDLE;
               latched   = 1'b0;
            end
         end
         default: begin
            phase_now = PHASE_CODE_IDLE;
            latched   = 1'b0;
            if (!enc_a_was && a) begin
               if (b) begin
                  if (target_wt != '0) target_wt = target_wt - 1'b1;
               end else if (target_wt < TARGET_MAX) begin
                  target_wt = target_wt + 1'b1;
               end
            end
            enc_a_was = a;
            if (press) begin
               tare_wt   = w;
               brew_ms   = '0;
               phase_now = PHASE_CODE_BREW;
            end
         end
      endcase
      st.phase        = phase_now;
      st.pump_on      = (phase_now == PHASE_CODE_BREW);
      st.goal_weight  = target_wt;
      st.shot_weight  = net_weight(w);
      st.shot_time_ms = brew_ms;
      st.last_weight  = last_wt;
      st.last_time_ms = last_ms;
      st.shot_done    = done;
      return st;
   endfunction

   task automatic check_field(input string field, input logic signed [16:0] exp_val,
                              input logic signed [16:0] got_val);
      if (got_val !== exp_val) begin
         fail_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         debounce_cfg = DEBOUNCE_RESET;
         cancel_cfg   = CANCEL_RESET;
         min_stop_cfg = MIN_STOP_RESET;
         max_shot_cfg = MAX_SHOT_RESET;
         drip_cfg     = DRIP_RESET;
         phase_now    = PHASE_CODE_IDLE;
         since_press  = '0;
         brew_ms      = '0;
         drip_ticks   = '0;
         tare_wt      = '0;
         target_wt    = TARGET_RESET;
         enc_a_was    = 1'b1;
         latched      = 1'b0;
         last_wt      = '0;
         last_ms      = '0;
         status_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_DEBOUNCE:     debounce_cfg = csr_mon.data[DEBOUNCE_W-1:0];
               CSR_CANCEL_LIMIT: cancel_cfg   = csr_mon.data;
               CSR_MIN_STOP:     min_stop_cfg = csr_mon.data;
               CSR_MAX_SHOT:     max_shot_cfg = csr_mon.data;
               CSR_DRIP:         drip_cfg     = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_due.size() == 0) begin
               fail_count++;
               $display("%0t: status item with none due, phase %0d", $time,
                        rsp_mon.phase);
            end else begin
               want = status_due.pop_front();
               check_field("phase", want.phase, rsp_mon.phase);
               check_field("pump_on", want.pump_on, rsp_mon.pump_on);
               check_field("goal_weight", want.goal_weight, rsp_mon.goal_weight);
               check_field("shot_weight", $signed(want.shot_weight), rsp_mon.shot_weight);
               check_field("shot_time_ms", want.shot_time_ms, rsp_mon.shot_time_ms);
               check_field("last_weight", $signed(want.last_weight), rsp_mon.last_weight);
               check_field("last_time_ms", want.last_time_ms, rsp_mon.last_time_ms);
               check_field("shot_done", want.shot_done, rsp_mon.shot_done);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            status_due.push_back(advance_tick(req_mon.button_press, req_mon.enc_a,
                                              req_mon.enc_b, req_mon.scale_weight));
         end
      end
      pending = status_due.size();
   end

endmodule

FILE: tb/tb_brew_by_weight_shot_controller.sv
// ----------------------------------------------------------------------------
// tb_brew_by_weight_shot_controller
// Drives millisecond ticks into the shot controller: a directed opening,
// random shots under several timing settings with stalls on both sides, and
// a final run without stalls that steps the target both ways and runs one long
// shot on random weights. The checker counts mismatches.
// ----------------------------------------------------------------------------
module tb_brew_by_weight_shot_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import bbw_pkg::*;

   localparam int CYCLE_LIMIT  = 50_000;
   localparam int PHASE_ITEMS  = 50;
   localparam int LONG_TICKS   = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAY = CSR_DRIP + 3'd1;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_pct = 0;
   int   shots_fed = 0;
   int   cycle_count = 0;
   logic a_level = 1'b1;

   bbw_req_if req_ch ();
   bbw_rsp_if rsp_ch ();
   bbw_csr_if csr_ch ();

   brew_by_weight_shot_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_ch),
      .rsp_item  (rsp_ch),
      .csr_write (csr_ch)
   );

   shot_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int hold;
      hold = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            hold = $urandom_range(0, 5);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_tick(input logic press, input logic a, input logic b,
                            input logic signed [WEIGHT_W-1:0] w);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.button_press <= press;
      req_ch.enc_a        <= a;
      req_ch.enc_b        <= b;
      req_ch.scale_weight <= w;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_timing(input logic [CSR_DATA_W-1:0] debounce,
                              input logic [CSR_DATA_W-1:0] cancel,
                              input logic [CSR_DATA_W-1:0] min_stop,
                              input logic [CSR_DATA_W-1:0] max_shot,
                              input logic [CSR_DATA_W-1:0] drip);
      logic [5:0] junk;
      junk = 6'($urandom);
      write_reg(CSR_DEBOUNCE, {junk, debounce[DEBOUNCE_W-1:0]});
      write_reg(CSR_CANCEL_LIMIT, cancel);
      write_reg(CSR_MIN_STOP, min_stop);
      write_reg(CSR_MAX_SHOT, max_shot);
      write_reg(CSR_DRIP, drip);
      write_reg(CSR_STRAY + 3'($urandom_range(0, 2)), 16'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic feed(input logic press, input logic a, input logic b,
                       input logic signed [WEIGHT_W-1:0] w);
      if ($urandom_range(0, 99) < 12) begin
         send_tick(1'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      end else begin
         send_tick(press, a, b, w);
      end
      shots_fed++;
   endtask

   task automatic run_shots(input int items, input int brew_span, input int drip_span);
      int goal;
      int ramp;
      int n;
      logic signed [WEIGHT_W-1:0] tare;
      logic signed [WEIGHT_W-1:0] w;
      goal = shots_fed + items;
      while (shots_fed < goal) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(0, 1)) a_level = ~a_level;
            feed(1'b0, a_level, 1'($urandom), 16'($urandom_range(0, 40) - 20));
         end
         if ($urandom_range(0, 3) == 0) tare = 16'($urandom);
         else tare = 16'($urandom_range(0, 400) - 200);
         feed(1'b1, a_level, 1'($urandom), tare);
         w    = tare;
         ramp = $urandom_range(0, 80);
         n    = $urandom_range(1, brew_span + 3);
         for (int k = 1; k <= n; k++) begin
            w = 16'(int'(tare) + ramp * k + $urandom_range(0, 6) - 3);
            feed(1'($urandom_range(0, 19) == 0), 1'($urandom), 1'($urandom), w);
         end
         n = $urandom_range(0, drip_span + 4);
         repeat (n) feed(1'b0, a_level, 1'b0, 16'(int'(w) + $urandom_range(0, 4) - 2));
         feed(1'b1, a_level, 1'b0, w);
      end
   endtask

   initial begin
      int cancel;
      int min_stop;
      int max_shot;
      int drip;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.button_press <= 1'b0;
      req_ch.enc_a        <= 1'b1;
      req_ch.enc_b        <= 1'b0;
      req_ch.scale_weight <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_DEBOUNCE;
      csr_ch.data         <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: encoder both ways, tare at both weight limits, debounce,
      // weight stop below the cancel limit, drip latch, cancel
      load_timing(16'd1, 16'd20, 16'd3, 16'd12, 16'd2);
      send_tick(1'b0, 1'b1, 1'b0, 16'sd0);
      send_tick(1'b0, 1'b0, 1'b0, 16'sd0);
      send_tick(1'b0, 1'b1, 1'b0, 16'sd0);
      send_tick(1'b0, 1'b0, 1'b1, 16'sd0);
      send_tick(1'b0, 1'b1, 1'b1, 16'sd0);
      send_tick(1'b1, 1'b1, 1'b1, 16'h8000);
      send_tick(1'b1, 1'b1, 1'b1, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b0, 16'h7FFF);
      send_tick(1'b0, 1'b1, 1'b0, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b0, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b0, 16'sd100);
      send_tick(1'b0, 1'b0, 1'b0, 16'sd200);
      send_tick(1'b0, 1'b0, 1'b0, 16'sd300);
      send_tick(1'b1, 1'b0, 1'b0, 16'sd0);
      send_tick(1'b1, 1'b0, 1'b0, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b0, 16'sd0);
      send_tick(1'b1, 1'b0, 1'b0, 16'h7FFF);
      send_tick(1'b0, 1'b0, 1'b0, 16'h8000);
      send_tick(1'b1, 1'b0, 1'b0, 16'h8000);
      send_tick(1'b0, 1'b1, 1'b0, 16'sd0);
      drain_results();

      idle_pct = 15;
      load_timing(16'd0, 16'd5, 16'd8, 16'd30, 16'd4);
      run_shots(PHASE_ITEMS, 30, 4);
      drain_results();

      idle_pct = 30;
      load_timing(16'd3, 16'd0, 16'd0, 16'd1, 16'd0);
      run_shots(PHASE_ITEMS, 1, 0);
      drain_results();

      // pump stops on the first brewing tick
      idle_pct = 0;
      load_timing(16'd2, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
      run_shots(PHASE_ITEMS, 1, 1);
      drain_results();

      repeat (3) begin
         cancel   = $urandom_range(0, 20);
         min_stop = $urandom_range(0, 20);
         max_shot = $urandom_range(0, 40);
         drip     = $urandom_range(0, 8);
         idle_pct = 15 * $urandom_range(0, 2);
         load_timing(16'($urandom_range(0, 4)), 16'(cancel), 16'(min_stop),
                     16'(max_shot), 16'(drip));
         run_shots(PHASE_ITEMS, max_shot, drip);
         drain_results();
      end

      // steady traffic from here on
      idle_pct = 0;
      load_timing(16'd0, 16'd4, 16'd6, 16'd20, 16'd5);
      repeat (12) begin
         send_tick(1'b0, 1'b0, 1'b0, 16'($urandom));
         send_tick(1'b0, 1'b1, 1'b0, 16'($urandom));
      end
      repeat (6) begin
         send_tick(1'b0, 1'b0, 1'b1, 16'($urandom));
         send_tick(1'b0, 1'b1, 1'b1, 16'($urandom));
      end
      send_tick(1'b1, 1'b1, 1'b0, 16'($urandom));
      for (int k = 1; k <= LONG_TICKS; k++) begin
         send_tick(1'(k < 4 && $urandom_range(0, 7) == 0), 1'($urandom),
                   1'($urandom), 16'($urandom));
      end
      send_tick(1'b1, 1'b1, 1'b0, 16'($urandom));
      repeat (5) send_tick(1'b0, 1'b1, 1'b0, 16'($urandom));
      drain_results();

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
